>>> design/awcrg_pkg.sv
// shared types and constants for the add-with-carry random generator
// used by awcrg_core, awcrg_divider and the top level; depends on nothing

package awcrg_pkg;

   localparam int unsigned WORD_W    = 32;
   localparam int unsigned NUM_WORDS = 6;
   localparam int unsigned IDX_W     = 3;
   localparam int unsigned SPAN_W    = WORD_W + 1;

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_WORDS - 1);

   // request function codes
   localparam logic [1:0] FUNC_RESEED = 2'd0;
   localparam logic [1:0] FUNC_RAW    = 2'd1;
   localparam logic [1:0] FUNC_RANGE  = 2'd2;

   typedef enum logic [1:0] {
      C_IDLE,
      C_ADC,
      C_INC,
      C_SEED
   } core_state_type;

   typedef enum logic [1:0] {
      T_IDLE,
      T_CORE,
      T_DIV,
      T_FINISH
   } top_state_type;

   typedef struct packed {
      logic              start;
      logic              reseed;
      logic [WORD_W-1:0] seed;
   } awcrg_cmd_type;

   function automatic logic [WORD_W-1:0] seed_const(input logic [IDX_W-1:0] idx);
      logic [WORD_W-1:0] value;
      unique case (idx)
         3'd0:    value = 32'hf22d0e56;
         3'd1:    value = 32'h883126e9;
         3'd2:    value = 32'hc624dd2f;
         3'd3:    value = 32'h0702c49c;
         3'd4:    value = 32'h9e353f7d;
         3'd5:    value = 32'h6fdf3b64;
         default: value = '0;
      endcase
      return value;
   endfunction

endpackage

>>> design/add_with_carry_random_generator_unit.sv
// add-with-carry random generator, one request at a time.
// reseed: the core rewrites all six generator words; raw draw: the shared adder
// steps through five carry adds and up to six increment steps;
// range draw: the word then runs through the bit-serial remainder unit.
// empty range (lo >= hi): no draw. next request taken when idle.
// synchronous reset loads the generator words as if reseeded with zero.

module add_with_carry_random_generator_unit import awcrg_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [1:0]               req_func,
   input  logic [WORD_W-1:0]        req_seed_word,
   input  logic signed [WORD_W-1:0] req_range_low,
   input  logic signed [WORD_W-1:0] req_range_high,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [WORD_W-1:0]        rsp_raw_word,
   output logic signed [WORD_W-1:0] rsp_ranged_value
);

   top_state_type     state_ff, state_in;
   logic [1:0]        func_ff, func_in;
   logic [WORD_W-1:0] lo_ff, lo_in;
   logic [SPAN_W-1:0] span_ff, span_in;
   logic [WORD_W-1:0] res_raw_ff, res_raw_in;
   logic [WORD_W-1:0] res_ranged_ff, res_ranged_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [WORD_W-1:0] rsp_raw_ff, rsp_raw_in;
   logic [WORD_W-1:0] rsp_ranged_ff, rsp_ranged_in;

   awcrg_cmd_type     core_cmd;
   logic              core_done;
   logic [WORD_W-1:0] core_word;
   logic              div_start;
   logic              div_done;
   logic [WORD_W-1:0] div_rem;

   logic [WORD_W-1:0] range_diff;
   logic              out_free;

   // hi - lo is exact in 32 bits when hi > lo
   assign range_diff = WORD_W'(req_range_high - req_range_low);
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   awcrg_core u_core (
      .clock (clock),
      .reset (reset),
      .cmd   (core_cmd),
      .done  (core_done),
      .word  (core_word)
   );

   awcrg_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (core_word),
      .divisor   (span_ff),
      .done      (div_done),
      .remainder (div_rem)
   );

   always_comb begin
      state_in       = state_ff;
      func_in        = func_ff;
      lo_in          = lo_ff;
      span_in        = span_ff;
      res_raw_in     = res_raw_ff;
      res_ranged_in  = res_ranged_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_raw_in     = rsp_raw_ff;
      rsp_ranged_in  = rsp_ranged_ff;
      core_cmd.start  = 1'b0;
      core_cmd.reseed = 1'b0;
      core_cmd.seed   = req_seed_word;
      div_start      = 1'b0;
      unique case (state_ff)
         T_IDLE: begin
            if (req_valid) begin
               func_in = req_func;
               lo_in   = req_range_low;
               span_in = {1'b0, range_diff} + SPAN_W'(1);
               unique case (req_func)
                  FUNC_RESEED: begin
                     core_cmd.start  = 1'b1;
                     core_cmd.reseed = 1'b1;
                     state_in        = T_CORE;
                  end
                  FUNC_RAW: begin
                     core_cmd.start = 1'b1;
                     state_in       = T_CORE;
                  end
                  FUNC_RANGE: begin
                     if (req_range_low >= req_range_high) begin
                        // empty or single range: no draw
                        res_raw_in    = '0;
                        res_ranged_in = req_range_high;
                        state_in      = T_FINISH;
                     end else begin
                        core_cmd.start = 1'b1;
                        state_in       = T_CORE;
                     end
                  end
                  default: begin
                     state_in = T_IDLE;
                  end
               endcase
            end
         end
         T_CORE: begin
            if (core_done) begin
               unique case (func_ff)
                  FUNC_RAW: begin
                     res_raw_in    = core_word;
                     res_ranged_in = '0;
                     state_in      = T_FINISH;
                  end
                  FUNC_RANGE: begin
                     res_raw_in = core_word;
                     div_start  = 1'b1;
                     state_in   = T_DIV;
                  end
                  default: begin
                     state_in = T_IDLE;
                  end
               endcase
            end
         end
         T_DIV: begin
            if (div_done) begin
               res_ranged_in = lo_ff + div_rem;
               state_in      = T_FINISH;
            end
         end
         T_FINISH: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_raw_in    = res_raw_ff;
               rsp_ranged_in = res_ranged_ff;
               state_in      = T_IDLE;
            end
         end
         default: begin
            state_in = T_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= T_IDLE;
         func_ff      <= FUNC_RESEED;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         func_ff      <= func_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff         <= lo_in;
      span_ff       <= span_in;
      res_raw_ff    <= res_raw_in;
      res_ranged_ff <= res_ranged_in;
      rsp_raw_ff    <= rsp_raw_in;
      rsp_ranged_ff <= rsp_ranged_in;
   end

   assign req_stall        = (state_ff != T_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_raw_word     = rsp_raw_ff;
   assign rsp_ranged_value = rsp_ranged_ff;

endmodule

>>> design/awcrg_core.sv
// generator word store with one shared 32-bit adder under a small sequencer
// runs reseed, the add-with-carry chain and the increment ripple; uses awcrg_pkg

module awcrg_core import awcrg_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  awcrg_cmd_type     cmd,
   output logic              done,
   output logic [WORD_W-1:0] word
);

   core_state_type    state_ff, state_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic [WORD_W-1:0] acc_ff, acc_in;
   logic              cy_ff, cy_in;
   logic [WORD_W-1:0] seed_ff, seed_in;
   logic              done_ff, done_in;
   logic [WORD_W-1:0] words_ff [0:NUM_WORDS-1];

   logic              we;
   logic [WORD_W-1:0] add_a, add_b;
   logic              add_cin;
   logic [WORD_W-1:0] sum;
   logic              carry_q;

   // shared adder
   always_comb begin
      add_a   = '0;
      add_b   = '0;
      add_cin = 1'b0;
      unique case (state_ff)
         C_ADC: begin
            add_a   = acc_ff;
            add_b   = words_ff[idx_ff];
            add_cin = cy_ff;
         end
         C_INC: begin
            add_a   = words_ff[idx_ff];
            add_cin = 1'b1;
         end
         C_SEED: begin
            add_a = seed_ff;
            add_b = seed_const(idx_ff);
         end
         default: begin
            add_a = '0;
         end
      endcase
   end

   assign sum      = add_a + add_b + WORD_W'(add_cin);
   // carry taken as "sum below either operand", not the true carry out
   assign carry_q  = (sum < add_a) || (sum < add_b);

   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      acc_in   = acc_ff;
      cy_in    = cy_ff;
      seed_in  = seed_ff;
      done_in  = 1'b0;
      we       = 1'b0;
      unique case (state_ff)
         C_IDLE: begin
            if (cmd.start) begin
               if (cmd.reseed) begin
                  seed_in  = cmd.seed;
                  idx_in   = LAST_IDX;
                  state_in = C_SEED;
               end else begin
                  acc_in   = words_ff[NUM_WORDS-1];
                  idx_in   = LAST_IDX - IDX_W'(1);
                  cy_in    = 1'b0;
                  state_in = C_ADC;
               end
            end
         end
         C_ADC: begin
            we     = 1'b1;
            acc_in = sum;
            cy_in  = carry_q;
            if (idx_ff == '0) begin
               idx_in   = LAST_IDX;
               state_in = C_INC;
            end else begin
               idx_in = idx_ff - IDX_W'(1);
            end
         end
         C_INC: begin
            we = 1'b1;
            if (idx_ff == '0) begin
               // word 0 holds the drawn word, so its bump is the bumped output
               acc_in   = sum;
               done_in  = 1'b1;
               state_in = C_IDLE;
            end else if (sum != '0) begin
               done_in  = 1'b1;
               state_in = C_IDLE;
            end else begin
               idx_in = idx_ff - IDX_W'(1);
            end
         end
         C_SEED: begin
            we = 1'b1;
            if (idx_ff == '0) begin
               done_in  = 1'b1;
               state_in = C_IDLE;
            end else begin
               idx_in = idx_ff - IDX_W'(1);
            end
         end
         default: begin
            state_in = C_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= C_IDLE;
         idx_ff   <= '0;
         cy_ff    <= 1'b0;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         cy_ff    <= cy_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff  <= acc_in;
      seed_ff <= seed_in;
   end

   // reset value is the state seeded with zero
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_WORDS; i++) begin
            words_ff[i] <= seed_const(IDX_W'(i));
         end
      end else if (we) begin
         words_ff[idx_ff] <= sum;
      end
   end

   assign done = done_ff;
   assign word = acc_ff;

endmodule

>>> design/awcrg_divider.sv
// restoring remainder unit, one quotient bit per cycle
// 32-bit dividend by 33-bit divisor; uses awcrg_pkg

module awcrg_divider import awcrg_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [WORD_W-1:0] dividend,
   input  logic [SPAN_W-1:0] divisor,
   output logic              done,
   output logic [WORD_W-1:0] remainder
);

   localparam int unsigned CNT_W = $clog2(WORD_W);

   logic              active_ff, active_in;
   logic              done_ff, done_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [WORD_W-1:0] quo_ff, quo_in;
   logic [WORD_W-1:0] rem_ff, rem_in;
   logic [SPAN_W-1:0] div_ff, div_in;

   logic [SPAN_W-1:0] trial;
   logic [SPAN_W:0]   diff;

   assign trial = {rem_ff, quo_ff[WORD_W-1]};
   assign diff  = {1'b0, trial} - {1'b0, div_ff};

   always_comb begin
      active_in = active_ff;
      done_in   = 1'b0;
      count_in  = count_ff;
      quo_in    = quo_ff;
      rem_in    = rem_ff;
      div_in    = div_ff;
      if (active_ff) begin
         quo_in = {quo_ff[WORD_W-2:0], 1'b0};
         // partial remainder stays below the divisor, so 32 bits hold it
         if (!diff[SPAN_W]) begin
            rem_in = diff[WORD_W-1:0];
         end else begin
            rem_in = trial[WORD_W-1:0];
         end
         if (count_ff == '0) begin
            active_in = 1'b0;
            done_in   = 1'b1;
         end else begin
            count_in = count_ff - CNT_W'(1);
         end
      end else if (start) begin
         active_in = 1'b1;
         count_in  = CNT_W'(WORD_W - 1);
         quo_in    = dividend;
         rem_in    = '0;
         div_in    = divisor;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         done_ff   <= 1'b0;
         count_ff  <= '0;
      end else begin
         active_ff <= active_in;
         done_ff   <= done_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule
